### src/rpct_pkg.sv
package rpct_pkg;

    localparam int unsigned SLOTS_DEF = 16;
    localparam logic [7:0] RETRANSMIT_AFTER_RST = 8'd3;
    localparam logic [7:0] MAX_RETRANSMIT_RST = 8'd60;

    localparam logic [2:0] CMD_ISSUE = 3'd0;
    localparam logic [2:0] CMD_REPLY = 3'd1;
    localparam logic [2:0] CMD_TICK = 3'd2;
    localparam logic [2:0] CMD_INIT_FAIL = 3'd3;
    localparam logic [2:0] CMD_RETX_FAIL = 3'd4;

    localparam logic [3:0] EV_ISSUED = 4'd0;
    localparam logic [3:0] EV_FULL = 4'd1;
    localparam logic [3:0] EV_DELIVERED = 4'd2;
    localparam logic [3:0] EV_NOT_REPLY = 4'd3;
    localparam logic [3:0] EV_UNKNOWN = 4'd4;
    localparam logic [3:0] EV_MALFORMED = 4'd5;
    localparam logic [3:0] EV_RETRANSMIT = 4'd6;
    localparam logic [3:0] EV_TIMEOUT = 4'd7;
    localparam logic [3:0] EV_ACK = 4'd8;
    localparam logic [3:0] EV_TICK_DONE = 4'd9;
    localparam logic [3:0] EV_SHORT = 4'd10;

    localparam logic [1:0] REG_RETX_AFTER = 2'd0;
    localparam logic [1:0] REG_MAX_RETX = 2'd1;
    localparam logic [1:0] REG_INIT_XID = 2'd2;

    // per-cell operation, broadcast to all cells
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_ALLOC  = 3'd1,
        OP_FREE   = 3'd2,
        OP_REARM  = 3'd3,
        OP_TICK   = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] xid;
        logic [7:0]  retx_after;
        logic [7:0]  max_retx;
    } cell_cmd_t;

    typedef struct packed {
        logic        valid;
        logic        match;
        logic        fire;
        logic        timeout;
        logic [31:0] xid;
    } cell_stat_t;

endpackage

### src/rpc_outstanding_call_tracker.sv
// channel | direction | handshake          | payload
// input   | in        | in_valid/in_stall  | command, xid, dest_port, status flags and words
// result  | out       | out_valid/out_stall| event_res, event_xid, slot, port, statuses, last
// config  | in        | apb write/read     | retransmit_after, max_retransmit, initial_xid
// issue, reply and send failures are decided on acceptance and give one result transfer
// a tick applies to all cells at once, then walks the captured flags one slot
// per cycle while the output register is free, with one result per firing slot
// and a final tick done result
// one item is in work at a time; a result waits in the output register under stall
// reset clears valid bits and the issue counter, and config registers to their reset values
module rpc_outstanding_call_tracker
    import rpct_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [31:0] xid,
    input  logic [15:0] dest_port,
    input  logic        short_packet,
    input  logic        is_reply,
    input  logic        auth_ok,
    input  logic [31:0] reply_stat,
    input  logic [31:0] accept_stat,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_res,
    output logic [31:0] event_xid,
    output logic [3:0]  slot,
    output logic [15:0] port,
    output logic [31:0] out_reply_stat,
    output logic [31:0] out_accept_stat,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [7:0]  retx_after_reg;
    logic [7:0]  max_retx_reg;
    logic [31:0] init_xid_reg;
    logic [31:0] issue_cnt_reg;
    logic [15:0] last_port_reg;
    logic [SW-1:0] walk_reg;
    logic [SLOTS-1:0] fire_reg;
    logic [SLOTS-1:0] tmo_reg;
    logic [31:0] fxid_reg [SLOTS];

    cell_cmd_t   ccmd;
    cell_stat_t  cstat [SLOTS];
    logic [SLOTS:0] free_ch;
    logic [SLOTS:0] match_ch;
    logic [SLOTS-1:0] sel;
    logic [SW-1:0] free_idx;
    logic [SW-1:0] match_idx;
    logic        accept_in;
    logic        out_free;
    logic        load;
    logic [3:0]  o_ev;
    logic [31:0] o_xid;
    logic [3:0]  o_slot;
    logic [31:0] o_rs;
    logic [31:0] o_as;
    logic        o_last;
    logic [31:0] new_xid;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RETX_AFTER: prdata = {24'd0, retx_after_reg};
            REG_MAX_RETX:   prdata = {24'd0, max_retx_reg};
            REG_INIT_XID:   prdata = init_xid_reg;
            default:        prdata = 32'd0;
        endcase
    end

    assign out_free = !out_valid || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept_in = in_valid && !in_stall;
    assign new_xid = init_xid_reg + issue_cnt_reg;

    assign free_ch[0] = 1'b0;
    assign match_ch[0] = 1'b0;

    always_comb
    begin
        free_idx = '0;
        match_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!cstat[i].valid)
            begin
                free_idx = SW'(i);
            end
            if (cstat[i].match)
            begin
                match_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        ccmd.op = OP_NONE;
        ccmd.xid = xid;
        ccmd.retx_after = retx_after_reg;
        ccmd.max_retx = max_retx_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            sel[i] = 1'b0;
        end
        if (accept_in)
        begin
            unique case (command)
                CMD_ISSUE:
                begin
                    ccmd.op = OP_ALLOC;
                    ccmd.xid = new_xid;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        sel[i] = !cstat[i].valid && !free_ch[i];
                    end
                end
                CMD_REPLY:
                begin
                    if (!short_packet && is_reply)
                    begin
                        ccmd.op = OP_FREE;
                    end
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        sel[i] = cstat[i].match && !match_ch[i];
                    end
                end
                CMD_TICK: ccmd.op = OP_TICK;
                CMD_INIT_FAIL, CMD_RETX_FAIL:
                begin
                    ccmd.op = (command == CMD_INIT_FAIL) ? OP_FREE : OP_REARM;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        sel[i] = cstat[i].match && !match_ch[i];
                    end
                end
                default: ccmd.op = OP_NONE;
            endcase
        end
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        rpct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (ccmd),
            .sel      (sel[g]),
            .free_in  (free_ch[g]),
            .free_out (free_ch[g+1]),
            .match_in (match_ch[g]),
            .match_out(match_ch[g+1]),
            .stat     (cstat[g])
        );
    end

    always_comb
    begin
        load = 1'b0;
        o_ev = EV_TICK_DONE;
        o_xid = 32'd0;
        o_slot = 4'd0;
        o_rs = 32'd0;
        o_as = 32'd0;
        o_last = 1'b1;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    unique case (command)
                        CMD_ISSUE:
                        begin
                            load = 1'b1;
                            o_xid = new_xid;
                            if (free_ch[SLOTS])
                            begin
                                o_ev = EV_ISSUED;
                                o_slot = 4'(free_idx);
                            end
                            else
                            begin
                                o_ev = EV_FULL;
                            end
                        end
                        CMD_REPLY:
                        begin
                            load = 1'b1;
                            o_xid = xid;
                            priority if (short_packet)
                            begin
                                o_ev = EV_SHORT;
                                o_xid = 32'd0;
                            end
                            else if (!is_reply)
                            begin
                                o_ev = EV_NOT_REPLY;
                            end
                            else if (!match_ch[SLOTS])
                            begin
                                o_ev = EV_UNKNOWN;
                            end
                            else
                            begin
                                o_slot = 4'(match_idx);
                                if (reply_stat != 32'd0)
                                begin
                                    o_ev = EV_DELIVERED;
                                    o_rs = reply_stat;
                                    o_as = 32'hFFFF_FFFF;
                                end
                                else if (!auth_ok)
                                begin
                                    o_ev = EV_MALFORMED;
                                end
                                else
                                begin
                                    o_ev = EV_DELIVERED;
                                    o_as = accept_stat;
                                end
                            end
                        end
                        CMD_TICK: state_next = ST_WALK;
                        CMD_INIT_FAIL, CMD_RETX_FAIL:
                        begin
                            load = 1'b1;
                            o_xid = xid;
                            if (match_ch[SLOTS])
                            begin
                                o_ev = EV_ACK;
                                o_slot = 4'(match_idx);
                            end
                            else
                            begin
                                o_ev = EV_UNKNOWN;
                            end
                        end
                        default: load = 1'b0;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (out_free)
                begin
                    if (fire_reg[walk_reg])
                    begin
                        load = 1'b1;
                        o_last = 1'b0;
                        o_xid = fxid_reg[walk_reg];
                        o_slot = 4'(walk_reg);
                        if (tmo_reg[walk_reg])
                        begin
                            o_ev = EV_TIMEOUT;
                            o_rs = 32'hFFFF_FFFF;
                            o_as = 32'hFFFF_FFFF;
                        end
                        else
                        begin
                            o_ev = EV_RETRANSMIT;
                        end
                    end
                    if (32'(walk_reg) == SLOTS - 1)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            retx_after_reg <= RETRANSMIT_AFTER_RST;
            max_retx_reg <= MAX_RETRANSMIT_RST;
            init_xid_reg <= 32'd0;
            issue_cnt_reg <= 32'd0;
            last_port_reg <= 16'd0;
            walk_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_RETX_AFTER: retx_after_reg <= pwdata[7:0];
                    REG_MAX_RETX:   max_retx_reg <= pwdata[7:0];
                    REG_INIT_XID:   init_xid_reg <= pwdata;
                    default:        init_xid_reg <= init_xid_reg;
                endcase
            end
            if (accept_in && command == CMD_ISSUE)
            begin
                issue_cnt_reg <= issue_cnt_reg + 32'd1;
                if (free_ch[SLOTS])
                begin
                    last_port_reg <= dest_port;
                end
            end
            if (state_reg == ST_WALK && out_free)
            begin
                walk_reg <= walk_reg + SW'(1);
            end
            else if (state_reg != ST_WALK)
            begin
                walk_reg <= '0;
            end
            if (load)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in && command == CMD_TICK)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                fire_reg[i] <= cstat[i].fire;
                tmo_reg[i] <= cstat[i].timeout;
                fxid_reg[i] <= cstat[i].xid;
            end
        end
        if (load)
        begin
            event_res <= o_ev;
            event_xid <= o_xid;
            slot <= o_slot;
            out_reply_stat <= o_rs;
            out_accept_stat <= o_as;
            last <= o_last;
            if (accept_in && command == CMD_ISSUE && free_ch[SLOTS])
            begin
                port <= dest_port;
            end
            else
            begin
                port <= last_port_reg;
            end
        end
    end

endmodule

### src/rpct_cell.sv
module rpct_cell
    import rpct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  logic       sel,
    input  logic       free_in,
    output logic       free_out,
    input  logic       match_in,
    output logic       match_out,
    output cell_stat_t stat
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] xid_reg;
    logic [31:0] xid_next;
    logic [7:0]  ticks_reg;
    logic [7:0]  ticks_next;
    logic [7:0]  retries_reg;
    logic [7:0]  retries_next;
    logic [7:0]  tick_inc;
    logic        hit;
    logic        fire;

    assign hit = valid_reg && (xid_reg == cmd.xid);
    assign free_out = free_in || !valid_reg;
    assign match_out = match_in || hit;
    assign tick_inc = (ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1;
    assign fire = valid_reg && (tick_inc >= cmd.retx_after);

    assign stat.valid = valid_reg;
    assign stat.match = hit;
    assign stat.fire = fire;
    assign stat.timeout = fire && (retries_reg == cmd.max_retx);
    assign stat.xid = xid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        xid_next = xid_reg;
        ticks_next = ticks_reg;
        retries_next = retries_reg;
        unique case (cmd.op)
            OP_ALLOC:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    xid_next = cmd.xid;
                    ticks_next = 8'd0;
                    retries_next = 8'd0;
                end
            end
            OP_FREE:
            begin
                if (sel)
                begin
                    valid_next = 1'b0;
                end
            end
            OP_REARM:
            begin
                if (sel)
                begin
                    ticks_next = (cmd.retx_after == 8'd0) ? 8'd0 : cmd.retx_after - 8'd1;
                end
            end
            OP_TICK:
            begin
                if (valid_reg)
                begin
                    ticks_next = tick_inc;
                    if (fire)
                    begin
                        if (retries_reg == cmd.max_retx)
                        begin
                            valid_next = 1'b0;
                        end
                        else
                        begin
                            retries_next = retries_reg + 8'd1;
                            ticks_next = 8'd0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xid_reg <= xid_next;
        ticks_reg <= ticks_next;
        retries_reg <= retries_next;
    end

endmodule

### src/rpct_checker.sv
module rpct_checker
    import rpct_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  event_res,
    input logic        last
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res <= EV_SHORT)
        else $error("bad event code");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_RETRANSMIT || event_res == EV_TIMEOUT) |-> !last)
        else $error("timer event flagged last");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_RETRANSMIT && event_res != EV_TIMEOUT |-> last)
        else $error("final event not flagged last");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall || !out_valid || last)
        else $error("new transfer accepted mid item");

endmodule

bind rpc_outstanding_call_tracker rpct_checker u_rpct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .last      (last)
);

### tb/tb_top.sv
class call_table_scoreboard;
    logic [7:0]  retx_after;
    logic [7:0]  max_retx;
    logic [31:0] first_xid;
    logic        used [16];
    logic [31:0] call_xid [16];
    logic [7:0]  call_ticks [16];
    logic [7:0]  call_retries [16];
    logic [31:0] issue_count;
    logic [15:0] last_port;
    logic [132:0] pending [$];
    int          errors;

    function new();
        retx_after = rpct_pkg::RETRANSMIT_AFTER_RST;
        max_retx = rpct_pkg::MAX_RETRANSMIT_RST;
        first_xid = '0;
        issue_count = '0;
        last_port = '0;
        errors = 0;
        for (int i = 0; i < 16; i++)
        begin
            used[i] = 1'b0;
            call_xid[i] = '0;
            call_ticks[i] = '0;
            call_retries[i] = '0;
        end
    endfunction

    function void push_event(logic [3:0] ev, logic [31:0] x, logic [3:0] s, logic [31:0] rs,
                             logic [31:0] as, logic lst);
        pending.push_back({ev, x, s, last_port, rs, as, 12'd0, lst});
    endfunction

    function int find_call(logic [31:0] x);
        for (int i = 0; i < 16; i++)
            if (used[i] && call_xid[i] == x)
                return i;
        return -1;
    endfunction

    // note an accepted input transfer
    function void note_input(logic [2:0] cmd, logic [31:0] x, logic [15:0] dport, logic shortp,
                             logic isrep, logic authok, logic [31:0] rstat, logic [31:0] astat);
        logic [31:0] nx;
        int s;
        case (cmd)
            rpct_pkg::CMD_ISSUE:
            begin
                nx = first_xid + issue_count;
                issue_count++;
                s = -1;
                for (int i = 15; i >= 0; i--)
                    if (!used[i])
                        s = i;
                if (s < 0)
                    push_event(rpct_pkg::EV_FULL, nx, 4'd0, 32'd0, 32'd0, 1'b1);
                else
                begin
                    used[s] = 1;
                    call_xid[s] = nx;
                    call_ticks[s] = 0;
                    call_retries[s] = 0;
                    last_port = dport;
                    push_event(rpct_pkg::EV_ISSUED, nx, 4'(s), 32'd0, 32'd0, 1'b1);
                end
            end
            rpct_pkg::CMD_REPLY:
            begin
                s = find_call(x);
                if (shortp)
                    push_event(rpct_pkg::EV_SHORT, 32'd0, 4'd0, 32'd0, 32'd0, 1'b1);
                else if (!isrep)
                    push_event(rpct_pkg::EV_NOT_REPLY, x, 4'd0, 32'd0, 32'd0, 1'b1);
                else if (s < 0)
                    push_event(rpct_pkg::EV_UNKNOWN, x, 4'd0, 32'd0, 32'd0, 1'b1);
                else
                begin
                    used[s] = 0;
                    if (rstat != 0)
                        push_event(rpct_pkg::EV_DELIVERED, x, 4'(s), rstat, '1, 1'b1);
                    else if (!authok)
                        push_event(rpct_pkg::EV_MALFORMED, x, 4'(s), 32'd0, 32'd0, 1'b1);
                    else
                        push_event(rpct_pkg::EV_DELIVERED, x, 4'(s), 32'd0, astat, 1'b1);
                end
            end
            rpct_pkg::CMD_TICK:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if (!used[i])
                        continue;
                    if (call_ticks[i] != 8'hff)
                        call_ticks[i]++;
                    if (call_ticks[i] >= retx_after)
                    begin
                        if (call_retries[i] == max_retx)
                        begin
                            used[i] = 0;
                            push_event(rpct_pkg::EV_TIMEOUT, call_xid[i], 4'(i), '1, '1, 1'b0);
                        end
                        else
                        begin
                            call_retries[i]++;
                            call_ticks[i] = 0;
                            push_event(rpct_pkg::EV_RETRANSMIT, call_xid[i], 4'(i), 32'd0, 32'd0,
                                       1'b0);
                        end
                    end
                end
                push_event(rpct_pkg::EV_TICK_DONE, 32'd0, 4'd0, 32'd0, 32'd0, 1'b1);
            end
            rpct_pkg::CMD_INIT_FAIL, rpct_pkg::CMD_RETX_FAIL:
            begin
                s = find_call(x);
                if (s < 0)
                    push_event(rpct_pkg::EV_UNKNOWN, x, 4'd0, 32'd0, 32'd0, 1'b1);
                else
                begin
                    if (cmd == rpct_pkg::CMD_INIT_FAIL)
                        used[s] = 0;
                    else
                        call_ticks[s] = (retx_after != 8'd0) ? retx_after - 8'd1 : 8'd0;
                    push_event(rpct_pkg::EV_ACK, x, 4'(s), 32'd0, 32'd0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void report(string what, logic [132:0] got, logic [132:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endfunction

    // check one result transfer
    function void check_result(logic [132:0] got);
        logic [132:0] want;
        if (pending.size() == 0)
        begin
            report("unexpected result", got, 0);
            return;
        end
        want = pending.pop_front();
        if (got[132:129] !== want[132:129]) report("event_res", got, want);
        if (got[128:97] !== want[128:97]) report("event_xid", got, want);
        if (got[96:93] !== want[96:93]) report("slot", got, want);
        if (got[92:77] !== want[92:77]) report("port", got, want);
        if (got[76:45] !== want[76:45]) report("out_reply_stat", got, want);
        if (got[44:13] !== want[44:13]) report("out_accept_stat", got, want);
        if (got[0] !== want[0]) report("last", got, want);
    endfunction
endclass

module tb_top;
    import rpct_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  command = 0;
    logic [31:0] xid = 0;
    logic [15:0] dest_port = 0;
    logic        short_packet = 0;
    logic        is_reply = 0;
    logic        auth_ok = 0;
    logic [31:0] reply_stat = 0;
    logic [31:0] accept_stat = 0;
    logic        out_valid;
    logic        out_stall = 1;
    logic [3:0]  event_res;
    logic [31:0] event_xid;
    logic [3:0]  slot;
    logic [15:0] port;
    logic [31:0] out_reply_stat;
    logic [31:0] out_accept_stat;
    logic        last;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    call_table_scoreboard calls = new();
    int          stall_left = 0;

    rpc_outstanding_call_tracker i_dut (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    initial
    begin
        #20000000;
        $display("tb_top NOT OK");
        $finish;
    end

    function int gap_len();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: random stall runs, check at the edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            calls.check_result({event_res, event_xid, slot, port, out_reply_stat,
                                out_accept_stat, 12'd0, last});
        if (!rst_n)
            out_stall <= 1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left <= gap_len();
            out_stall <= 1;
        end
        else
            out_stall <= 0;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_RETX_AFTER: calls.retx_after = val[7:0];
            REG_MAX_RETX: calls.max_retx = val[7:0];
            default: calls.first_xid = val;
        endcase
    endtask

    task automatic drain();
        while (calls.pending.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic send(logic [2:0] cmd, logic [31:0] x, logic [15:0] dport, logic shortp,
                        logic isrep, logic authok, logic [31:0] rstat, logic [31:0] astat);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            @(posedge clk);
            in_valid <= 0;
            repeat (g - 1) @(posedge clk);
        end
        @(posedge clk);
        in_valid <= 1;
        command <= cmd;
        xid <= x;
        dest_port <= dport;
        short_packet <= shortp;
        is_reply <= isrep;
        auth_ok <= authok;
        reply_stat <= rstat;
        accept_stat <= astat;
        do
            @(posedge clk);
        while (in_stall);
        calls.note_input(cmd, x, dport, shortp, isrep, authok, rstat, astat);
        in_valid <= 0;
    endtask

    function automatic logic [31:0] live_xid();
        int s;
        s = $urandom_range(0, 15);
        for (int k = 0; k < 16; k++)
            if (calls.used[(s + k) % 16])
                return calls.call_xid[(s + k) % 16];
        return $urandom;
    endfunction

    task automatic random_item();
        int r;
        logic [31:0] x;
        r = $urandom_range(0, 99);
        x = ($urandom_range(0, 4) != 0) ? live_xid() : $urandom;
        if (r < 35)
            send(CMD_ISSUE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (r < 60)
            send(CMD_REPLY, x, $urandom, ($urandom_range(0, 9) == 0), ($urandom_range(0, 9) != 0),
                 ($urandom_range(0, 5) != 0), ($urandom_range(0, 1) ? 0 : $urandom),
                 $urandom);
        else if (r < 85)
            send(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (r < 92)
            send(CMD_INIT_FAIL, x, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (r < 98)
            send(CMD_RETX_FAIL, x, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            send(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        // directed
        send(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
        send(CMD_REPLY, 32'h5, 0, 1, 1, 1, 0, 0);
        send(CMD_REPLY, '1, 0, 0, 0, 1, 0, 0);
        send(CMD_REPLY, 32'h77, 0, 0, 1, 1, 0, 0);
        for (int i = 0; i < 17; i++)
            send(CMD_ISSUE, 0, (i == 0) ? 16'hffff : 16'(i), 0, 0, 0, 0, 0);
        send(CMD_REPLY, 0, 0, 0, 1, 1, 0, '1);
        send(CMD_REPLY, 1, 0, 0, 1, 0, 0, 0);
        send(CMD_REPLY, 2, 0, 0, 1, 1, '1, 0);
        send(CMD_INIT_FAIL, 3, 0, 0, 0, 0, 0, 0);
        send(CMD_RETX_FAIL, 4, 0, 0, 0, 0, 0, 0);
        send(CMD_RETX_FAIL, 99, 0, 0, 0, 0, 0, 0);
        send(3'd7, 0, 0, 0, 0, 0, 0, 0);
        drain();
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_RETX_AFTER, 1); write_reg(REG_MAX_RETX, 0);
                         write_reg(REG_INIT_XID, 32'hfffffff8); end
                1: begin write_reg(REG_RETX_AFTER, 255); write_reg(REG_MAX_RETX, 254); end
                2: begin write_reg(REG_RETX_AFTER, 0); write_reg(REG_MAX_RETX, 1); end
                3: begin write_reg(REG_RETX_AFTER, $urandom_range(1, 4));
                         write_reg(REG_MAX_RETX, $urandom_range(0, 3));
                         write_reg(REG_INIT_XID, $urandom); end
                default: begin write_reg(REG_RETX_AFTER, 2); write_reg(REG_MAX_RETX, 2); end
            endcase
            for (int n = 0; n < 90; n++)
                random_item();
            drain();
        end
        drain();
        if (calls.errors == 0 && calls.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

### files.f
src/rpct_pkg.sv
src/rpct_cell.sv
src/rpc_outstanding_call_tracker.sv
src/rpct_checker.sv
tb/tb_top.sv
